// ----- src/thle_pkg.sv -----
// Package for the timer heap block: command and result codes, default sizes.
// Used by every module under src; depends on nothing.
package thle_pkg;

    localparam int CAPACITY_DEF = 32;
    localparam int HANDLE_BITS_DEF = 8;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [1:0] CMD_ADD = 2'd0;
    localparam logic [1:0] CMD_CANCEL = 2'd1;
    localparam logic [1:0] CMD_SWEEP = 2'd2;

    localparam logic [2:0] KIND_ADDED = 3'd0;
    localparam logic [2:0] KIND_CANCELLED = 3'd1;
    localparam logic [2:0] KIND_EXPIRED = 3'd2;
    localparam logic [2:0] KIND_SWEPT = 3'd3;
    localparam logic [2:0] KIND_FULL = 3'd4;

    // Classified command passed from the front part to the back part.
    typedef enum logic [1:0] {
        OP_ADD,
        OP_CANCEL,
        OP_SWEEP
    } op_t;

endpackage

// ----- src/thle_front.sv -----
// Front part: accepts input transactions, drops unused commands, computes the
// expiry time and queues the classified operation. Depends on thle_pkg.
module thle_front #(
    parameter int HANDLE_BITS = thle_pkg::HANDLE_BITS_DEF
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_stall,
    input  logic [1:0]               cmd,
    input  logic [7:0]               handle,
    input  logic [15:0]              timeout_ms,
    input  logic [31:0]              now_ms,
    output logic                     q_valid,
    input  logic                     q_take,
    output thle_pkg::op_t            q_op,
    output logic [HANDLE_BITS-1:0]   q_handle,
    output logic [31:0]              q_time
);

    localparam int D = thle_pkg::QUEUE_DEPTH;

    thle_pkg::op_t          op_reg [D];
    logic [HANDLE_BITS-1:0] hd_reg [D];
    logic [31:0]            tm_reg [D];
    logic                   wp_reg, wp_next, rp_reg, rp_next;
    logic [1:0]             cnt_reg, cnt_next;
    logic                   push, pop, useful;
    logic [HANDLE_BITS-1:0] hmask;
    thle_pkg::op_t          op_in;

    always_comb
    begin
        hmask = '0;
        for (int b = 0; b < HANDLE_BITS; b++)
        begin
            hmask[b] = (b < 8) ? handle[b % 8] : 1'b0;
        end
    end

    always_comb
    begin
        useful = 1'b1;
        op_in = thle_pkg::OP_ADD;
        case (cmd)
            thle_pkg::CMD_ADD:    op_in = thle_pkg::OP_ADD;
            thle_pkg::CMD_CANCEL: op_in = thle_pkg::OP_CANCEL;
            thle_pkg::CMD_SWEEP:  op_in = thle_pkg::OP_SWEEP;
            default:              useful = 1'b0;
        endcase
    end

    assign in_stall = (cnt_reg == 2'(D));
    assign push = in_valid && !in_stall && useful;
    assign q_valid = (cnt_reg != 2'd0);
    assign pop = q_valid && q_take;
    assign q_op = op_reg[rp_reg];
    assign q_handle = hd_reg[rp_reg];
    assign q_time = tm_reg[rp_reg];

    always_comb
    begin
        wp_next = push ? ~wp_reg : wp_reg;
        rp_next = pop ? ~rp_reg : rp_reg;
        cnt_next = 2'(cnt_reg + {1'b0, push} - {1'b0, pop});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg <= 1'b0;
            rp_reg <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            wp_reg <= wp_next;
            rp_reg <= rp_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            op_reg[wp_reg] <= op_in;
            hd_reg[wp_reg] <= hmask;
            // Add carries the expiry, sweep carries the current time.
            tm_reg[wp_reg] <= (op_in == thle_pkg::OP_ADD) ?
                              now_ms + {16'd0, timeout_ms} : now_ms;
        end
    end

endmodule

// ----- src/thle_back.sv -----
// Back part: holds the heap in registers and runs add, cancel and sweep as a
// sequencer, one sift level per cycle. Depends on thle_pkg.
module thle_back #(
    parameter int CAPACITY    = thle_pkg::CAPACITY_DEF,
    parameter int HANDLE_BITS = thle_pkg::HANDLE_BITS_DEF
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     q_valid,
    output logic                     q_take,
    input  thle_pkg::op_t            q_op,
    input  logic [HANDLE_BITS-1:0]   q_handle,
    input  logic [31:0]              q_time,
    output logic                     out_valid,
    input  logic                     out_stall,
    output logic [2:0]               kind,
    output logic [7:0]               expired_handle,
    output logic                     last
);

    localparam int IW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_UP,
        S_CANCEL,
        S_TOP,
        S_DOWN,
        S_EMIT
    } state_t;

    state_t                 state_reg;
    logic [31:0]            exp_reg [CAPACITY];
    logic [HANDLE_BITS-1:0] hdl_reg [CAPACITY];
    logic                   can_reg [CAPACITY];
    logic [CW-1:0]          count_reg;
    logic [IW-1:0]          idx_reg;
    logic [HANDLE_BITS-1:0] h_reg;
    logic [31:0]            now_reg;
    logic                   out_valid_reg;
    logic [2:0]             kind_reg;
    logic [7:0]             eh_reg;
    logic                   last_reg;

    logic [IW-1:0] parent, lc, rc, sc;
    logic          l_ok, r_ok;
    logic [7:0]    top_h8;
    logic          out_free;
    logic          top_pops;
    logic          emit;

    assign out_free = !out_valid_reg || !out_stall;
    assign q_take = (state_reg == S_IDLE) && out_free;
    assign out_valid = out_valid_reg;
    assign kind = kind_reg;
    assign expired_handle = eh_reg;
    assign last = last_reg;

    // The top leaves the heap when it is cancelled or already due.
    assign top_pops = (count_reg != '0) && (can_reg[0] || !(exp_reg[0] > now_reg));

    // A result is loaded into the output register this cycle.
    assign emit = out_free &&
                  ((state_reg == S_IDLE && q_valid && q_op == thle_pkg::OP_ADD &&
                    count_reg >= CW'(CAPACITY)) ||
                   (state_reg == S_TOP && !(top_pops && can_reg[0])) ||
                   (state_reg == S_EMIT));

    always_comb
    begin
        parent = IW'((idx_reg - 1'b1) >> 1);
        lc = IW'({idx_reg, 1'b1});
        rc = IW'(lc + 1'b1);
        l_ok = ({1'b0, idx_reg, 1'b1} < (CW + 1)'(count_reg));
        r_ok = ({1'b0, idx_reg, 1'b1} + 1'b1 < (CW + 1)'(count_reg));
        sc = (r_ok && exp_reg[rc] < exp_reg[lc]) ? rc : lc;
        top_h8 = '0;
        for (int b = 0; b < 8; b++)
        begin
            top_h8[b] = (b < HANDLE_BITS) ? hdl_reg[0][b % HANDLE_BITS] : 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            idx_reg <= '0;
            out_valid_reg <= 1'b0;
            h_reg <= '0;
            now_reg <= '0;
            kind_reg <= '0;
            eh_reg <= '0;
            last_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= emit || (out_valid_reg && out_stall);
            case (state_reg)
                S_IDLE:
                begin
                    if (q_valid && out_free)
                    begin
                        h_reg <= q_handle;
                        now_reg <= q_time;
                        idx_reg <= '0;
                        case (q_op)
                            thle_pkg::OP_ADD:
                            begin
                                if (count_reg >= CW'(CAPACITY))
                                begin
                                    kind_reg <= thle_pkg::KIND_FULL;
                                    eh_reg <= '0;
                                    last_reg <= 1'b1;
                                end
                                else
                                begin
                                    exp_reg[IW'(count_reg)] <= q_time;
                                    hdl_reg[IW'(count_reg)] <= q_handle;
                                    can_reg[IW'(count_reg)] <= 1'b0;
                                    idx_reg <= IW'(count_reg);
                                    count_reg <= CW'(count_reg + 1'b1);
                                    state_reg <= S_UP;
                                end
                            end
                            thle_pkg::OP_CANCEL:
                            begin
                                state_reg <= S_CANCEL;
                            end
                            default:
                            begin
                                state_reg <= S_TOP;
                            end
                        endcase
                    end
                end
                S_UP:
                begin
                    if (idx_reg != '0 && exp_reg[idx_reg] < exp_reg[parent])
                    begin
                        exp_reg[idx_reg] <= exp_reg[parent];
                        hdl_reg[idx_reg] <= hdl_reg[parent];
                        can_reg[idx_reg] <= can_reg[parent];
                        exp_reg[parent] <= exp_reg[idx_reg];
                        hdl_reg[parent] <= hdl_reg[idx_reg];
                        can_reg[parent] <= can_reg[idx_reg];
                        idx_reg <= parent;
                    end
                    else
                    begin
                        state_reg <= S_EMIT;
                        kind_reg <= thle_pkg::KIND_ADDED;
                    end
                end
                S_CANCEL:
                begin
                    for (int i = 0; i < CAPACITY; i++)
                    begin
                        if (CW'(i) < count_reg && hdl_reg[i] == h_reg)
                        begin
                            can_reg[i] <= 1'b1;
                        end
                    end
                    state_reg <= S_EMIT;
                    kind_reg <= thle_pkg::KIND_CANCELLED;
                end
                S_TOP:
                begin
                    if (out_free)
                    begin
                        if (top_pops)
                        begin
                            if (!can_reg[0])
                            begin
                                kind_reg <= thle_pkg::KIND_EXPIRED;
                                eh_reg <= top_h8;
                                last_reg <= 1'b0;
                            end
                            exp_reg[0] <= exp_reg[IW'(count_reg - 1'b1)];
                            hdl_reg[0] <= hdl_reg[IW'(count_reg - 1'b1)];
                            can_reg[0] <= can_reg[IW'(count_reg - 1'b1)];
                            count_reg <= CW'(count_reg - 1'b1);
                            idx_reg <= '0;
                            state_reg <= S_DOWN;
                        end
                        else
                        begin
                            kind_reg <= thle_pkg::KIND_SWEPT;
                            eh_reg <= '0;
                            last_reg <= 1'b1;
                            state_reg <= S_IDLE;
                        end
                    end
                end
                S_DOWN:
                begin
                    if (l_ok && exp_reg[sc] < exp_reg[idx_reg])
                    begin
                        exp_reg[idx_reg] <= exp_reg[sc];
                        hdl_reg[idx_reg] <= hdl_reg[sc];
                        can_reg[idx_reg] <= can_reg[sc];
                        exp_reg[sc] <= exp_reg[idx_reg];
                        hdl_reg[sc] <= hdl_reg[idx_reg];
                        can_reg[sc] <= can_reg[idx_reg];
                        idx_reg <= sc;
                    end
                    else
                    begin
                        state_reg <= S_TOP;
                    end
                end
                S_EMIT:
                begin
                    if (out_free)
                    begin
                        eh_reg <= '0;
                        last_reg <= 1'b1;
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

// ----- src/timer_heap_lazy_expiry.sv -----
// Top level of the timer heap with lazy cancellation.
// Instantiates thle_front and thle_back; depends on thle_pkg.
//
//   channel   signals                                   direction
//   input     in_valid, in_stall, cmd, handle,          into the block
//             timeout_ms, now_ms
//   output    out_valid, out_stall, kind,               out of the block
//             expired_handle, last
//
// An add is written at the end of the heap and sifted up, one heap level per
// cycle, before its result. A cancel marks every matching entry at once, then
// gives its result. A sweep pops each due or cancelled top entry, reporting the
// due ones, and sifts the heap down after each pop; then it gives the done result.
// Reset clears the heap count and the queue; stored entries are not cleared.
// A two-entry queue lets the front accept while the back works; a stalled
// result holds the back sequencer in its idle, top and emit states until it is taken.
module timer_heap_lazy_expiry #(
    parameter int CAPACITY    = thle_pkg::CAPACITY_DEF,
    parameter int HANDLE_BITS = thle_pkg::HANDLE_BITS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  cmd,
    input  logic [7:0]  handle,
    input  logic [15:0] timeout_ms,
    input  logic [31:0] now_ms,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [2:0]  kind,
    output logic [7:0]  expired_handle,
    output logic        last
);

    // Queue between the front and back parts.
    logic                   q_valid;
    logic                   q_take;
    thle_pkg::op_t          q_op;
    logic [HANDLE_BITS-1:0] q_handle;
    logic [31:0]            q_time;

    thle_front #(
        .HANDLE_BITS(HANDLE_BITS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .cmd        (cmd),
        .handle     (handle),
        .timeout_ms (timeout_ms),
        .now_ms     (now_ms),
        .q_valid    (q_valid),
        .q_take     (q_take),
        .q_op       (q_op),
        .q_handle   (q_handle),
        .q_time     (q_time)
    );

    thle_back #(
        .CAPACITY    (CAPACITY),
        .HANDLE_BITS (HANDLE_BITS)
    ) u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .q_valid        (q_valid),
        .q_take         (q_take),
        .q_op           (q_op),
        .q_handle       (q_handle),
        .q_time         (q_time),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .kind           (kind),
        .expired_handle (expired_handle),
        .last           (last)
    );

endmodule

// ----- bench/tb_timer_heap_lazy_expiry.sv -----
// Self-checking bench for timer_heap_lazy_expiry: a directed table, then random traffic.
// Holds its own heap predictor; depends on thle_pkg and the RTL under src.
module tb_timer_heap_lazy_expiry;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int HEAP_SLOTS = thle_pkg::CAPACITY_DEF;
    localparam int LIMIT_CYCLES = 2000000;

    typedef struct packed {
        logic [2:0] kind;
        logic [7:0] expired_handle;
        logic       last;
    } result_t;

    // One row of the directed table. When check_kind is set, the kind of the
    // first result is also compared with a value typed in by hand.
    typedef struct {
        logic [1:0]  cmd;
        logic [7:0]  handle;
        logic [15:0] timeout_ms;
        logic [31:0] now_ms;
        logic        check_kind;
        logic [2:0]  first_kind;
    } stim_row_t;

    typedef struct {
        logic [31:0] expiry;
        logic [7:0]  owner;
        logic        dead;
    } timer_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [1:0]  cmd = thle_pkg::CMD_ADD;
    logic [7:0]  handle = '0;
    logic [15:0] timeout_ms = '0;
    logic [31:0] now_ms = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [2:0]  kind;
    logic [7:0]  expired_handle;
    logic        last;

    timer_t  timers[HEAP_SLOTS];
    int      timer_count = 0;
    result_t pending_results[$];
    int      failures = 0;
    int      cycle_count = 0;
    int      results_seen = 0;
    int      expiries_seen = 0;
    int      items_sent = 0;
    int      send_idle_pct = 0;
    int      recv_stall_pct = 0;
    logic    kind_override_on = 1'b0;
    logic [2:0] kind_override;

    timer_heap_lazy_expiry u_top (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .cmd(cmd),
        .handle(handle),
        .timeout_ms(timeout_ms),
        .now_ms(now_ms),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .kind(kind),
        .expired_handle(expired_handle),
        .last(last)
    );

    always #1 clk = ~clk;

    // Heap helpers for the predictor. Ties keep the parent in place on the way
    // up and prefer the left child on the way down, which fixes the order in
    // which equal expiries come out.
    task automatic swap_timers(input int a, input int b);
        timer_t t;
        t = timers[a];
        timers[a] = timers[b];
        timers[b] = t;
    endtask

    task automatic sift_up_timer(input int idx);
        int i;
        int p;
        i = idx;
        while (i > 0) begin
            p = (i - 1) / 2;
            if (timers[i].expiry < timers[p].expiry) begin
                swap_timers(i, p);
                i = p;
            end
            else begin
                break;
            end
        end
    endtask

    task automatic sift_down_timer();
        int i;
        int l;
        int s;
        i = 0;
        forever begin
            l = 2 * i + 1;
            if (l >= timer_count) break;
            s = l;
            if (l + 1 < timer_count && timers[l + 1].expiry < timers[l].expiry) s = l + 1;
            if (timers[s].expiry < timers[i].expiry) begin
                swap_timers(s, i);
                i = s;
            end
            else begin
                break;
            end
        end
    endtask

    task automatic push_result(input logic [2:0] k, input logic [7:0] h, input logic l);
        result_t r;
        r.kind = k;
        r.expired_handle = h;
        r.last = l;
        pending_results.push_back(r);
    endtask

    // Works out the results of one accepted transaction and updates the heap.
    task automatic predict_timer_op(input logic [1:0] c, input logic [7:0] h,
                                    input logic [15:0] tmo, input logic [31:0] now);
        timer_t top;
        case (c)
            thle_pkg::CMD_ADD: begin
                if (timer_count >= HEAP_SLOTS) begin
                    push_result(thle_pkg::KIND_FULL, '0, 1'b1);
                end
                else begin
                    timers[timer_count].expiry = now + 32'(tmo);
                    timers[timer_count].owner = h;
                    timers[timer_count].dead = 1'b0;
                    timer_count++;
                    sift_up_timer(timer_count - 1);
                    push_result(thle_pkg::KIND_ADDED, '0, 1'b1);
                end
            end
            thle_pkg::CMD_CANCEL: begin
                for (int i = 0; i < timer_count; i++)
                    if (timers[i].owner == h) timers[i].dead = 1'b1;
                push_result(thle_pkg::KIND_CANCELLED, '0, 1'b1);
            end
            thle_pkg::CMD_SWEEP: begin
                while (timer_count > 0) begin
                    top = timers[0];
                    if (!top.dead && top.expiry > now) break;
                    timer_count--;
                    timers[0] = timers[timer_count];
                    sift_down_timer();
                    if (!top.dead) push_result(thle_pkg::KIND_EXPIRED, top.owner, 1'b0);
                end
                push_result(thle_pkg::KIND_SWEPT, '0, 1'b1);
            end
            default: begin
                // The unused code changes nothing and gives no result.
            end
        endcase
    endtask

    // Drives one transaction: optional idle cycles first, then valid held
    // until the block takes it at a rising edge with stall low. Valid stays
    // up afterwards until the next transaction or a drain replaces it.
    task automatic send_item(input logic [1:0] c, input logic [7:0] h,
                             input logic [15:0] tmo, input logic [31:0] now);
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        cmd <= c;
        handle <= h;
        timeout_ms <= tmo;
        now_ms <= now;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        predict_timer_op(c, h, tmo, now);
        items_sent++;
        @(negedge clk);
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        while (pending_results.size() != 0) @(negedge clk);
        repeat (40) @(negedge clk);
    endtask

    // The receiver stalls at random on the falling edge, so the stall seen
    // at each rising edge is stable.
    always @(negedge clk) begin
        if (rst_n) out_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    // Result checker: compares every accepted result with the oldest one due.
    always @(posedge clk) begin
        result_t want;
        if (rst_n && out_valid && !out_stall) begin
            results_seen++;
            if (kind == thle_pkg::KIND_EXPIRED) expiries_seen++;
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result kind=%0d handle=%0d last=%0d",
                         $realtime, kind, expired_handle, last);
                failures++;
            end
            else begin
                want = pending_results.pop_front();
                if (kind_override_on) begin
                    if (kind !== kind_override) begin
                        $display("%0t: table kind expected %0d actual %0d",
                                 $realtime, kind_override, kind);
                        failures++;
                    end
                    kind_override_on = 1'b0;
                end
                if (kind !== want.kind) begin
                    $display("%0t: kind expected %0d actual %0d", $realtime, want.kind, kind);
                    failures++;
                end
                if (expired_handle !== want.expired_handle) begin
                    $display("%0t: expired_handle expected %0d actual %0d",
                             $realtime, want.expired_handle, expired_handle);
                    failures++;
                end
                if (last !== want.last) begin
                    $display("%0t: last expected %0d actual %0d", $realtime, want.last, last);
                    failures++;
                end
            end
        end
    end

    // Watchdog on the cycle count.
    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count > LIMIT_CYCLES) begin
            $display("tb_timer_heap_lazy_expiry: FAIL");
            $finish;
        end
    end

    // Directed rows: extremes of every field, each command, the unused code,
    // cancel with no match, cancelled entries popped silently, and ties in expiry.
    stim_row_t dir_rows[$];

    task automatic add_row(input logic [1:0] c, input logic [7:0] h, input logic [15:0] tmo,
                           input logic [31:0] now, input logic ck, input logic [2:0] k);
        stim_row_t r;
        r.cmd = c;
        r.handle = h;
        r.timeout_ms = tmo;
        r.now_ms = now;
        r.check_kind = ck;
        r.first_kind = k;
        dir_rows.push_back(r);
    endtask

    task automatic run_phase(input int n_items);
        int roll;
        logic [31:0] now_base;
        now_base = $urandom_range(1000000);
        for (int n = 0; n < n_items; n++) begin
            roll = $urandom_range(99);
            now_base = now_base + $urandom_range(300);
            if (roll < 50) begin
                // Small handle set so cancels hit, timeouts short so sweeps fire.
                send_item(thle_pkg::CMD_ADD,
                          ($urandom_range(3) == 0) ? 8'($urandom) : 8'($urandom_range(7)),
                          ($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(600)),
                          ($urandom_range(19) == 0) ? 32'($urandom) : now_base);
            end
            else if (roll < 62) begin
                send_item(thle_pkg::CMD_CANCEL, ($urandom_range(3) == 0) ? 8'($urandom)
                                                                : 8'($urandom_range(7)),
                          16'($urandom), 32'($urandom));
            end
            else if (roll < 97) begin
                send_item(thle_pkg::CMD_SWEEP, 8'($urandom), 16'($urandom),
                          ($urandom_range(19) == 0) ? 32'($urandom) : now_base);
            end
            else begin
                send_item(2'd3, 8'($urandom), 16'($urandom), 32'($urandom));
            end
        end
    endtask

    initial begin
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        add_row(thle_pkg::CMD_SWEEP, 8'h00, 16'h0000, 32'h0000_0000, 1'b1,
                thle_pkg::KIND_SWEPT);
        add_row(thle_pkg::CMD_CANCEL, 8'hFF, 16'hFFFF, 32'hFFFF_FFFF, 1'b1,
                thle_pkg::KIND_CANCELLED);
        add_row(2'd3, 8'hAA, 16'h5555, 32'hA5A5_A5A5, 1'b0, thle_pkg::KIND_ADDED);
        add_row(thle_pkg::CMD_ADD, 8'hFF, 16'hFFFF, 32'hFFFF_0000, 1'b1,
                thle_pkg::KIND_ADDED);
        add_row(thle_pkg::CMD_ADD, 8'h00, 16'h0000, 32'h0000_0000, 1'b1,
                thle_pkg::KIND_ADDED);
        add_row(thle_pkg::CMD_ADD, 8'h55, 16'h0010, 32'h0000_0100, 1'b1,
                thle_pkg::KIND_ADDED);
        add_row(thle_pkg::CMD_ADD, 8'hAA, 16'h0010, 32'h0000_0100, 1'b0,
                thle_pkg::KIND_ADDED);
        add_row(thle_pkg::CMD_ADD, 8'h55, 16'h0020, 32'h0000_0100, 1'b0,
                thle_pkg::KIND_ADDED);
        add_row(thle_pkg::CMD_CANCEL, 8'h55, 16'h0000, 32'h0000_0000, 1'b1,
                thle_pkg::KIND_CANCELLED);
        add_row(thle_pkg::CMD_CANCEL, 8'h77, 16'h0000, 32'h0000_0000, 1'b1,
                thle_pkg::KIND_CANCELLED);
        add_row(thle_pkg::CMD_SWEEP, 8'h00, 16'h0000, 32'h0000_0200, 1'b0,
                thle_pkg::KIND_EXPIRED);
        add_row(thle_pkg::CMD_SWEEP, 8'h00, 16'h0000, 32'hFFFF_FFFF, 1'b0,
                thle_pkg::KIND_EXPIRED);
        foreach (dir_rows[i]) begin
            drain_results();
            kind_override_on = dir_rows[i].check_kind;
            kind_override = dir_rows[i].first_kind;
            send_item(dir_rows[i].cmd, dir_rows[i].handle, dir_rows[i].timeout_ms,
                      dir_rows[i].now_ms);
        end

        // Fill the heap past capacity; the surplus adds must report full.
        drain_results();
        for (int i = 0; i < HEAP_SLOTS + 2; i++) begin
            if (i >= HEAP_SLOTS) begin
                drain_results();
                kind_override_on = 1'b1;
                kind_override = thle_pkg::KIND_FULL;
            end
            send_item(thle_pkg::CMD_ADD, 8'(i), 16'(i % 5), 32'd1000);
        end
        drain_results();
        send_item(thle_pkg::CMD_SWEEP, 8'h00, 16'h0000, 32'd2000);

        // Random phases with different idling mixes; the sender pauses for a
        // full drain only after the first of them.
        send_idle_pct = 0;  recv_stall_pct = 0;  run_phase(100);
        drain_results();
        send_idle_pct = 47; recv_stall_pct = 0;  run_phase(90);
        send_idle_pct = 0;  recv_stall_pct = 47; run_phase(90);
        send_idle_pct = 20; recv_stall_pct = 20; run_phase(100);
        send_idle_pct = 0;  recv_stall_pct = 0;
        send_item(thle_pkg::CMD_SWEEP, 8'h00, 16'h0000, 32'hFFFF_FFFF);

        drain_results();
        $display("Sent %0d transactions, checked %0d results including %0d expiries.",
                 items_sent, results_seen, expiries_seen);
        if (failures == 0 && pending_results.size() == 0) begin
            $display("tb_timer_heap_lazy_expiry: PASS");
        end
        else begin
            $display("tb_timer_heap_lazy_expiry: FAIL");
        end
        $finish;
    end
endmodule
